// ----- src/led_bar_graph_meter_unit_defines.svh -----
// Assertion macros shared by the LED bar-graph meter RTL.
`ifndef LED_BAR_GRAPH_METER_UNIT_DEFINES_SVH
`define LED_BAR_GRAPH_METER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LBGM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LBGM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lbgm_pkg.sv -----
// Widths and codes for the LED bar-graph meter.
package lbgm_pkg;

  localparam int DATA_W    = 32;  // sample, min and max width
  localparam int OFF_W     = 7;   // window offset register width
  localparam int LEN_W     = 7;   // window length register and |length| width
  localparam int NUM_W     = 40;  // dividend 2*(s-min)*|len| + d
  localparam int REM_W     = 33;  // remainder, below 2*d
  localparam int POS_W     = 9;   // signed LED position arithmetic
  localparam int CNT_W     = 6;   // step counter, up to NUM_W-1
  localparam int LIT_W     = 6;   // lit_count width
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd3;

  localparam logic OP_SHOW  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic [DATA_W-1:0]       data_t;
  typedef logic signed [POS_W-1:0] pos_t;

endpackage

// ----- src/led_bar_graph_meter_unit.sv -----
// LED bar-graph level meter: serial multiply, bit-serial divide, window merge.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------------
//   in_     | input     | in_valid / in_ready   | in_operation, in_sample
//   out_    | output    | out_valid / out_ready | out_led_word, out_lit_count, out_range_fault
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Sequence: one item is in work at a time. A clear, a bad range or a sample at or beyond
// min or max steps from accept through compare to merge. A sample strictly inside
// the range runs 7 shift-add multiply steps over |window_length| after the compare,
// then one dividend bit per cycle through the restoring divider, then the merge.
// Reset (rst_n low, synchronous) loads the register defaults and blanks the LED line.
// A stalled result holds in the output register; the merge waits for it to drain.
module led_bar_graph_meter_unit #(
  parameter int LED_COUNT = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // item input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic signed [lbgm_pkg::DATA_W-1:0] in_sample,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lbgm_pkg::DATA_W-1:0]      out_led_word,
  output logic [lbgm_pkg::LIT_W-1:0]       out_lit_count,
  output logic                             out_range_fault,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbgm_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DATA_W = lbgm_pkg::DATA_W;
  localparam int LEN_W  = lbgm_pkg::LEN_W;
  localparam int NUM_W  = lbgm_pkg::NUM_W;
  localparam int REM_W  = lbgm_pkg::REM_W;
  localparam int POS_W  = lbgm_pkg::POS_W;
  localparam int CNT_W  = lbgm_pkg::CNT_W;
  localparam int LIT_W  = lbgm_pkg::LIT_W;
  localparam int OFF_W  = lbgm_pkg::OFF_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WIN  = 3'd4;

  // Configuration registers.
  logic signed [DATA_W-1:0] min_r, max_r;
  logic signed [OFF_W-1:0]  off_r;
  logic signed [LEN_W-1:0]  wlen_r;

  // Control and datapath registers.
  logic [2:0]               state_r, state_nxt;
  logic                     op_r;
  lbgm_pkg::data_t          sample_r;
  logic                     fault_r, fault_nxt;
  logic [DATA_W-1:0]        d_r, d_nxt;
  logic [NUM_W-1:0]         acc_r, acc_nxt;    // multiply accumulator, then dividend
  logic [NUM_W-1:0]         mcand_r, mcand_nxt;
  logic [LEN_W-1:0]         lsh_r, lsh_nxt;    // multiplier bits, LSB first
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [LEN_W-1:0]         bar_r, bar_nxt;    // bar length n, also quotient shift
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [LED_COUNT-1:0]     led_r, led_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_word_r, out_word_nxt;
  logic [LIT_W-1:0]         out_cnt_r, out_cnt_nxt;
  logic                     out_fault_r, out_fault_nxt;

  // Combinational helpers.
  logic [LEN_W-1:0]         len_abs;
  logic signed [DATA_W:0]   s_min, s_max, max_min;
  logic                     below, above, bad_range;
  logic [REM_W:0]           rem_sh;
  logic [REM_W:0]           den;
  logic                     rem_ge;
  logic                     win_load;
  lbgm_pkg::pos_t           ws, we, ls, le, lo, hi, line_end, pv;
  logic [LED_COUNT-1:0]     word;
  logic [LIT_W-1:0]         lit;

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_led_word    = out_word_r;
  assign out_lit_count   = out_cnt_r;
  assign out_range_fault = out_fault_r;

  // |window_length|; the most negative code gives 64.
  assign len_abs = wlen_r[LEN_W-1] ? LEN_W'(~wlen_r + 1'b1) : LEN_W'(wlen_r);

  // Range compares, 33-bit signed so that no difference overflows.
  assign s_min     = {sample_r[DATA_W-1], sample_r} - {min_r[DATA_W-1], min_r};
  assign s_max     = {sample_r[DATA_W-1], sample_r} - {max_r[DATA_W-1], max_r};
  assign max_min   = {max_r[DATA_W-1], max_r} - {min_r[DATA_W-1], min_r};
  assign below     = s_min[DATA_W] || (s_min == '0);
  assign above     = !s_max[DATA_W];
  assign bad_range = max_min[DATA_W] || (max_min == '0);

  // One restoring-division step: shift in the next dividend bit, try 2*d.
  assign den    = {1'b0, d_r, 1'b0};
  assign rem_sh = {rem_r, acc_r[NUM_W-1]};
  assign rem_ge = (rem_sh >= den);

  // Window and lit span in signed LED positions, position 0 at the MSB.
  always_comb begin
    ws       = POS_W'(off_r);
    we       = ws + $signed({2'b00, len_abs});
    line_end = $signed(POS_W'(LED_COUNT));
    if (wlen_r[LEN_W-1]) begin
      ls = we - $signed({2'b00, bar_r});
      le = we;
    end else begin
      ls = ws;
      le = ws + $signed({2'b00, bar_r});
    end
    lo  = ls[POS_W-1] ? '0 : ls;
    hi  = (le > line_end) ? line_end : le;
    lit = (hi > lo) ? LIT_W'(hi - lo) : '0;
  end

  // Merge the bar into the kept line; only window bits change.
  always_comb begin
    word = led_r;
    for (int p = 0; p < LED_COUNT; p++) begin
      pv = $signed(POS_W'(p));
      if (pv >= ws && pv < we) begin
        word[LED_COUNT-1-p] = (pv >= ls) && (pv < le);
      end
    end
  end

  assign win_load = (state_r == S_WIN) && (!out_valid_r || out_ready);

  // Sequencer and serial datapath.
  always_comb begin
    state_nxt     = state_r;
    fault_nxt     = fault_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    lsh_nxt       = lsh_r;
    rem_nxt       = rem_r;
    bar_nxt       = bar_r;
    cnt_nxt       = cnt_r;
    led_nxt       = led_r;
    out_word_nxt  = out_word_r;
    out_cnt_nxt   = out_cnt_r;
    out_fault_nxt = out_fault_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        fault_nxt = bad_range;
        d_nxt     = max_min[DATA_W-1:0];
        if (op_r == lbgm_pkg::OP_CLEAR || bad_range || below) begin
          bar_nxt   = '0;
          state_nxt = S_WIN;
        end else if (above) begin
          bar_nxt   = len_abs;
          state_nxt = S_WIN;
        end else begin
          // dividend = 2*(s-min)*|len| + d; start the sum at d
          acc_nxt   = NUM_W'(max_min[DATA_W-1:0]);
          mcand_nxt = NUM_W'({s_min[DATA_W-1:0], 1'b0});
          lsh_nxt   = len_abs;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (lsh_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = mcand_r << 1;
        lsh_nxt   = lsh_r >> 1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(LEN_W - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          bar_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_ge ? REM_W'(rem_sh - den) : REM_W'(rem_sh);
        bar_nxt = {bar_r[LEN_W-2:0], rem_ge};
        acc_nxt = acc_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        if (win_load) begin
          led_nxt       = word;
          out_word_nxt  = DATA_W'(word);
          out_cnt_nxt   = lit;
          out_fault_nxt = fault_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      led_r       <= '0;
      min_r       <= '0;
      max_r       <= DATA_W'(255);
      off_r       <= '0;
      wlen_r      <= LEN_W'(8);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      led_r       <= led_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lbgm_pkg::CFG_MIN_VALUE:     min_r  <= cfg_data;
          lbgm_pkg::CFG_MAX_VALUE:     max_r  <= cfg_data;
          lbgm_pkg::CFG_WINDOW_OFFSET: off_r  <= cfg_data[OFF_W-1:0];
          lbgm_pkg::CFG_WINDOW_LENGTH: wlen_r <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_operation;
      sample_r <= in_sample;
    end
    fault_r     <= fault_nxt;
    d_r         <= d_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    lsh_r       <= lsh_nxt;
    rem_r       <= rem_nxt;
    bar_r       <= bar_nxt;
    cnt_r       <= cnt_nxt;
    out_word_r  <= out_word_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_fault_r <= out_fault_nxt;
  end

`include "led_bar_graph_meter_unit_defines.svh"

  // The divider remainder stays below the divisor throughout the divide.
  `LBGM_ASSERT_NOW(a_rem_below_den, state_r == S_DIV, ({1'b0, rem_r} < den), "remainder too big")
  // The bar never runs past the full window length.
  `LBGM_ASSERT_NOW(a_bar_in_len, state_r == S_WIN, bar_r <= len_abs, "bar longer than window")
  // The LED line changes only when a result is loaded.
  `LBGM_ASSERT_NEXT(a_led_hold, !win_load, $stable(led_r), "LED line changed outside merge")
  // The lit count never exceeds the line.
  `LBGM_ASSERT_NOW(a_lit_max, out_valid, out_lit_count <= LIT_W'(LED_COUNT), "lit count too big")

endmodule
